@@ sv/spmf_pkg.sv @@
// spmf_pkg: shared types and constants of the strict priority multi-fifo
// used by strict_priority_multi_fifo and spmf_pick, depends on nothing
package spmf_pkg;

    localparam int ITEM_W  = 32;
    localparam int PRIO_W  = 4;
    localparam int CFG_W   = 4;
    localparam int ST_W    = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd8;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY   = 2'd3;

    localparam logic [PRIO_W-1:0] LEVEL_NONE = 4'hF;

    localparam logic FUNC_PUT = 1'b0;
    localparam logic FUNC_GET = 1'b1;

    typedef struct packed {
        logic              found;
        logic [PRIO_W-1:0] level;
    } pick_t;

endpackage

@@ sv/spmf_pick.sv @@
// spmf_pick: priority encoder over the per-level non-empty flags
// finds the lowest active level that holds an item; uses spmf_pkg
module spmf_pick #(
    parameter int NUM_LEVELS = 8
) (
    input  logic [NUM_LEVELS-1:0]      nonempty,
    input  logic [spmf_pkg::PRIO_W-1:0] levels,
    output spmf_pkg::pick_t            pick
);

    always_comb
    begin
        pick.found = 1'b0;
        pick.level = spmf_pkg::LEVEL_NONE;
        // scan from the lowest priority so level 0 wins last
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (nonempty[i] && (spmf_pkg::PRIO_W'(i) < levels))
            begin
                pick.found = 1'b1;
                pick.level = spmf_pkg::PRIO_W'(i);
            end
        end
    end

endmodule

@@ sv/strict_priority_multi_fifo.sv @@
// strict_priority_multi_fifo: one ring fifo per priority level in a shared item memory
// depends on spmf_pkg and spmf_pick
//
// usage:
// requests arrive on the s_ stream; s_tuser is the operation (0 put, 1 get),
// s_tdata carries the item handle and the put level. every request gives exactly
// one result on the m_ stream: m_tuser is the status (ok, invalid level, level
// full, all empty), m_tdata carries the dequeued item, its level, and the
// room-freed and data-arrived flags.
// the ring indices sit in a small synchronous index memory and the handles in a
// synchronous item memory, both with a registered read port. per-level empty and
// full flags in flip-flops feed the priority encoder for gets.
// a rejected request (invalid, full, empty) is answered at accept; a put reads the
// index, then writes index and item; a get reads index, then item, then answers.
// one request is in flight at a time; s_tready is high only while no request is
// being worked on. a result waits in the output register, or in a hold register
// behind it while m_tready is low, so a stalled receiver stops new requests.
// cfg_we writes the active level count; write it only while idle.
// reset empties all rings at once (index valid bits and flags clear), sets the
// active level count to 8, and leaves item memory contents as they are.
module strict_priority_multi_fifo #(
    parameter int NUM_LEVELS = 8,
    parameter int SLOTS      = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // config
    input  logic                                cfg_we,
    input  logic [spmf_pkg::CFG_W-1:0]          cfg_wdata,   // active_levels
    // request stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [spmf_pkg::IN_TDATA_W-1:0]     s_tdata,     // item[31:0], prio_level[35:32]
    input  logic                                s_tuser,     // func[0]
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [spmf_pkg::OUT_TDATA_W-1:0]    m_tdata,     // item_out[31:0], level_out[35:32],
                                                             // room_freed[36], data_arrived[37]
    output logic [spmf_pkg::ST_W-1:0]           m_tuser      // status[1:0]
);

    localparam int CELLS     = SLOTS + 1;
    localparam int IDX_W     = $clog2(CELLS);
    localparam int LVL_IDX_W = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int DEPTH     = NUM_LEVELS * CELLS;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PAD_W     = spmf_pkg::OUT_TDATA_W - spmf_pkg::ITEM_W - spmf_pkg::PRIO_W - 2;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_IDX  = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_HOLD = 2'd3;

    typedef struct packed {
        logic [IDX_W-1:0] w;
        logic [IDX_W-1:0] r;
    } ring_idx_t;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
        ring_next = (idx == IDX_W'(CELLS - 1)) ? '0 : idx + IDX_W'(1);
    endfunction

    // memories
    ring_idx_t                    idx_mem [NUM_LEVELS];
    logic [spmf_pkg::ITEM_W-1:0]  store_mem [DEPTH];

    logic [1:0]                   state_reg, state_next;
    logic [spmf_pkg::CFG_W-1:0]   active_reg;
    logic [NUM_LEVELS-1:0]        nonempty_reg, full_reg, idx_valid_reg;

    logic                         req_put_reg;
    logic [spmf_pkg::ITEM_W-1:0]  req_item_reg;
    logic [LVL_IDX_W-1:0]         req_lvl_reg;

    ring_idx_t                    idx_rdata_reg;
    logic                         idx_rvalid_reg;
    logic [spmf_pkg::ITEM_W-1:0]  store_rdata_reg;

    logic                         out_valid_reg;
    logic [spmf_pkg::ST_W-1:0]    out_status_reg;
    logic [spmf_pkg::ITEM_W-1:0]  out_item_reg;
    logic [spmf_pkg::PRIO_W-1:0]  out_level_reg;
    logic                         out_room_reg, out_arr_reg;

    logic [spmf_pkg::ST_W-1:0]    hold_status_reg;
    logic [spmf_pkg::ITEM_W-1:0]  hold_item_reg;
    logic [spmf_pkg::PRIO_W-1:0]  hold_level_reg;
    logic                         hold_room_reg, hold_arr_reg;

    logic [spmf_pkg::PRIO_W-1:0]  eff_levels;
    spmf_pkg::pick_t              pick;

    logic                         in_fire, in_put, in_invalid, in_full, in_empty;
    logic [spmf_pkg::PRIO_W-1:0]  in_prio;
    logic [LVL_IDX_W-1:0]         acc_lvl;

    ring_idx_t                    cur_idx, new_idx;
    logic [IDX_W-1:0]             w_next, r_next;
    logic [ADDR_W-1:0]            ring_base;

    logic                         fin_valid, out_free;
    logic [spmf_pkg::ST_W-1:0]    fin_status;
    logic [spmf_pkg::ITEM_W-1:0]  fin_item;
    logic [spmf_pkg::PRIO_W-1:0]  fin_level;
    logic                         fin_room, fin_arr;

    spmf_pick #(
        .NUM_LEVELS (NUM_LEVELS)
    ) u_pick (
        .nonempty (nonempty_reg),
        .levels   (eff_levels),
        .pick     (pick)
    );

    always_comb
    begin
        eff_levels = ({1'b0, active_reg} > (spmf_pkg::CFG_W + 1)'(NUM_LEVELS))
                     ? spmf_pkg::PRIO_W'(NUM_LEVELS) : active_reg;

        in_fire    = s_tvalid && s_tready;
        in_put     = (s_tuser == spmf_pkg::FUNC_PUT);
        in_prio    = s_tdata[spmf_pkg::ITEM_W +: spmf_pkg::PRIO_W];
        in_invalid = in_put && (in_prio >= eff_levels);
        in_full    = in_put && !in_invalid && full_reg[in_prio[LVL_IDX_W-1:0]];
        in_empty   = !in_put && !pick.found;
        acc_lvl    = in_put ? in_prio[LVL_IDX_W-1:0] : pick.level[LVL_IDX_W-1:0];

        // never-written index entries read as zero
        cur_idx   = idx_rvalid_reg ? idx_rdata_reg : '0;
        w_next    = ring_next(cur_idx.w);
        r_next    = ring_next(cur_idx.r);
        new_idx   = req_put_reg ? ring_idx_t'{w: w_next, r: cur_idx.r}
                                : ring_idx_t'{w: cur_idx.w, r: r_next};
        ring_base = ADDR_W'(req_lvl_reg) * ADDR_W'(CELLS);

        out_free  = !out_valid_reg || m_tready;

        fin_valid  = 1'b0;
        fin_status = spmf_pkg::ST_OK;
        fin_item   = '0;
        fin_level  = spmf_pkg::LEVEL_NONE;
        fin_room   = 1'b0;
        fin_arr    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (in_invalid || in_full || in_empty))
                begin
                    fin_valid  = 1'b1;
                    fin_status = in_invalid ? spmf_pkg::ST_INVALID :
                                 in_full    ? spmf_pkg::ST_FULL : spmf_pkg::ST_EMPTY;
                end
            end
            S_IDX:
            begin
                if (req_put_reg)
                begin
                    fin_valid = 1'b1;
                    fin_arr   = !nonempty_reg[req_lvl_reg];
                end
            end
            S_RD:
            begin
                fin_valid = 1'b1;
                fin_item  = store_rdata_reg;
                fin_level = spmf_pkg::PRIO_W'(req_lvl_reg);
                fin_room  = full_reg[req_lvl_reg];
            end
            S_HOLD:
            begin
                fin_valid  = 1'b1;
                fin_status = hold_status_reg;
                fin_item   = hold_item_reg;
                fin_level  = hold_level_reg;
                fin_room   = hold_room_reg;
                fin_arr    = hold_arr_reg;
            end
            default:
            begin
                fin_valid = 1'b0;
            end
        endcase

        state_next = state_reg;
        if (fin_valid)
            state_next = out_free ? S_IDLE : S_HOLD;
        else if (state_reg == S_IDLE && in_fire)
            state_next = S_IDX;
        else if (state_reg == S_IDX)
            state_next = S_RD;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_arr_reg, out_room_reg, out_level_reg, out_item_reg};

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= spmf_pkg::ACTIVE_RESET;
            nonempty_reg  <= '0;
            full_reg      <= '0;
            idx_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                active_reg <= cfg_wdata;
            if (state_reg == S_IDX)
            begin
                idx_valid_reg[req_lvl_reg] <= 1'b1;
                if (req_put_reg)
                begin
                    nonempty_reg[req_lvl_reg] <= 1'b1;
                    full_reg[req_lvl_reg]     <= (ring_next(w_next) == cur_idx.r);
                end
                else
                begin
                    nonempty_reg[req_lvl_reg] <= (r_next != cur_idx.w);
                end
            end
            // full flag of a get is cleared once the result has read it
            if (state_reg == S_RD)
                full_reg[req_lvl_reg] <= 1'b0;
            if (fin_valid && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // request, hold and output payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_put_reg  <= in_put;
            req_item_reg <= s_tdata[spmf_pkg::ITEM_W-1:0];
            req_lvl_reg  <= acc_lvl;
        end
        if (fin_valid && out_free)
        begin
            out_status_reg <= fin_status;
            out_item_reg   <= fin_item;
            out_level_reg  <= fin_level;
            out_room_reg   <= fin_room;
            out_arr_reg    <= fin_arr;
        end
        if (fin_valid && !out_free)
        begin
            hold_status_reg <= fin_status;
            hold_item_reg   <= fin_item;
            hold_level_reg  <= fin_level;
            hold_room_reg   <= fin_room;
            hold_arr_reg    <= fin_arr;
        end
    end

    // index memory: read at accept, write back in the index state
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            idx_rdata_reg  <= idx_mem[acc_lvl];
            idx_rvalid_reg <= idx_valid_reg[acc_lvl];
        end
        if (state_reg == S_IDX)
            idx_mem[req_lvl_reg] <= new_idx;
    end

    // item memory: put writes the tail cell, get reads the head cell
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDX && req_put_reg)
            store_mem[ring_base + ADDR_W'(cur_idx.w)] <= req_item_reg;
        if (state_reg == S_IDX && !req_put_reg)
            store_rdata_reg <= store_mem[ring_base + ADDR_W'(cur_idx.r)];
    end

endmodule
